// ----- sv/lge_pkg.sv -----
// Shared constants and types of the life grid generation engine.
// No dependencies; used by lge_ram users and the top level through scoped names.
package lge_pkg;

    localparam int GRID_WIDTH  = 32;
    localparam int GRID_HEIGHT = 32;

    localparam int ROW_ADDR_W = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    // sweep counter runs 0 .. GRID_HEIGHT+1
    localparam int STEP_CNT_W = $clog2(GRID_HEIGHT + 2);
    localparam int ROW_OUT_W  = 32;
    localparam int NBR_W      = 4;

    localparam logic [NBR_W-1:0] BIRTH_COUNT  = NBR_W'(3);
    localparam logic [NBR_W-1:0] SURVIVE_LOW  = NBR_W'(2);
    localparam logic [NBR_W-1:0] SURVIVE_HIGH = NBR_W'(3);

    typedef enum logic [1:0] {
        CMD_TOGGLE = 2'd0,
        CMD_STEP   = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_STEP = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

// ----- sv/lge_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lge_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]               wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]               rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/life_grid_generation_engine.sv -----
// Top level of the life grid generation engine (B3/S23 on a bounded grid).
// Depends on lge_pkg and lge_ram.
//
// Usage:
//   Requests enter on s_valid/s_ready with s_command, s_cell_x and s_cell_y.
//   Each request returns exactly one m_row_cells on m_valid/m_ready: the row
//   at s_cell_y after the command (toggle, step, or read; code 3 reads).
//   The grid lives in one row-wide RAM, one row per entry. A per-row valid
//   flag, cleared at reset, makes never-written rows read as dead, so the
//   grid is clear right after reset with no clearing pass.
//   Toggle and read pass ST_READ (modify and write back) and then ST_DONE
//   (output load) before m_valid; a step sweeps the RAM with a three-row
//   window in ST_STEP and then presents the result through ST_DONE.
//   One request is in work at a time; s_ready is high only when the engine
//   is idle, but a new request may be taken while the previous result still
//   sits in the output register. If m_ready stays low, the finished result
//   of the following request waits inside and the engine stalls.
//   aresetn is synchronous, active low; it clears the grid and the channels.
module life_grid_generation_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [4:0]  s_cell_x,
    input  logic [4:0]  s_cell_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_row_cells
);

    localparam int W  = lge_pkg::GRID_WIDTH;
    localparam int H  = lge_pkg::GRID_HEIGHT;
    localparam int AW = lge_pkg::ROW_ADDR_W;
    localparam int CW = lge_pkg::STEP_CNT_W;

    function automatic logic [W-1:0] life_row(input logic [W-1:0] up,
                                              input logic [W-1:0] mid,
                                              input logic [W-1:0] dn);
        logic [W+1:0] pu;
        logic [W+1:0] pm;
        logic [W+1:0] pd;
        logic [lge_pkg::NBR_W-1:0] n;
        logic [W-1:0] res;
        pu = {1'b0, up, 1'b0};
        pm = {1'b0, mid, 1'b0};
        pd = {1'b0, dn, 1'b0};
        res = '0;
        for (int x = 0; x < W; x++) begin
            n = lge_pkg::NBR_W'(pu[x]) + lge_pkg::NBR_W'(pu[x+1])
              + lge_pkg::NBR_W'(pu[x+2]) + lge_pkg::NBR_W'(pm[x])
              + lge_pkg::NBR_W'(pm[x+2]) + lge_pkg::NBR_W'(pd[x])
              + lge_pkg::NBR_W'(pd[x+1]) + lge_pkg::NBR_W'(pd[x+2]);
            if (pm[x+1]) begin
                res[x] = (n == lge_pkg::SURVIVE_LOW) || (n == lge_pkg::SURVIVE_HIGH);
            end else begin
                res[x] = (n == lge_pkg::BIRTH_COUNT);
            end
        end
        return res;
    endfunction

    lge_pkg::state_t state_reg, state_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [4:0]    x_reg, x_next;
    logic [4:0]    y_reg, y_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  above_reg, above_next;
    logic [W-1:0]  center_reg, center_next;
    logic [W-1:0]  result_reg, result_next;
    logic [H-1:0]  row_valid_reg, row_valid_next;
    logic          rd_valid_reg, rd_valid_next;
    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_row_reg, m_row_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [W-1:0]  wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [W-1:0]  rd_data;
    logic [W-1:0]  rd_row;
    logic [W-1:0]  below_row;
    logic [W-1:0]  new_row;
    logic          y_in_grid;
    logic          x_in_grid;
    logic          accept;

    lge_ram #(
        .WIDTH (W),
        .DEPTH (H)
    ) u_grid_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready     = (state_reg == lge_pkg::ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_row_cells = m_row_reg;

    assign y_in_grid = (32'(y_reg) < 32'(H));
    assign x_in_grid = (32'(x_reg) < 32'(W));
    // rows never written since reset read as dead
    assign rd_row    = rd_valid_reg ? rd_data : '0;
    // row below the one being produced; zero past the bottom edge
    assign below_row = ((cnt_reg >= CW'(1)) && (cnt_reg <= CW'(H))) ? rd_row : '0;
    assign new_row   = life_row(above_reg, center_reg, below_row);

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        cnt_next       = cnt_reg;
        above_next     = above_reg;
        center_next    = center_reg;
        result_next    = result_reg;
        row_valid_next = row_valid_reg;
        m_valid_next   = m_valid_reg;
        m_row_next     = m_row_reg;
        rd_en          = 1'b0;
        rd_addr        = AW'(y_reg);
        wr_en          = 1'b0;
        wr_addr        = AW'(y_reg);
        wr_data        = rd_row;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            lge_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd_next    = s_command;
                    x_next      = s_cell_x;
                    y_next      = s_cell_y;
                    cnt_next    = '0;
                    above_next  = '0;
                    center_next = '0;
                    result_next = '0;
                    if (s_command == lge_pkg::CMD_STEP) begin
                        state_next = lge_pkg::ST_STEP;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(s_cell_y);
                        state_next = lge_pkg::ST_READ;
                    end
                end
            end
            lge_pkg::ST_READ: begin
                result_next = y_in_grid ? rd_row : '0;
                if (cmd_reg == lge_pkg::CMD_TOGGLE && y_in_grid && x_in_grid) begin
                    wr_en          = 1'b1;
                    wr_data        = rd_row ^ (W'(1) << x_reg);
                    result_next    = wr_data;
                    row_valid_next[AW'(y_reg)] = 1'b1;
                end
                state_next = lge_pkg::ST_DONE;
            end
            lge_pkg::ST_STEP: begin
                // read row cnt, produce row cnt-2 from the window
                if (cnt_reg < CW'(H)) begin
                    rd_en   = 1'b1;
                    rd_addr = cnt_reg[AW-1:0];
                end
                above_next  = center_reg;
                center_next = below_row;
                if (cnt_reg >= CW'(2)) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(cnt_reg - CW'(2));
                    wr_data = new_row;
                    row_valid_next[AW'(cnt_reg - CW'(2))] = 1'b1;
                    if (y_in_grid && (32'(cnt_reg - CW'(2)) == 32'(y_reg))) begin
                        result_next = new_row;
                    end
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(H + 1)) begin
                    state_next = lge_pkg::ST_DONE;
                end
            end
            lge_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_row_next   = 32'(result_reg);
                    state_next   = lge_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lge_pkg::ST_IDLE;
            end
        endcase

        rd_valid_next = row_valid_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lge_pkg::ST_IDLE;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        above_reg    <= above_next;
        center_reg   <= center_next;
        result_reg   <= result_next;
        rd_valid_reg <= rd_valid_next;
        m_row_reg    <= m_row_next;
    end

endmodule
